// File: rtl/hill_terrain_accumulator_defines.svh
// Assertion macros for the hill terrain accumulator.
// Included by the top level; needs nothing else.
`ifndef HILL_TERRAIN_ACCUMULATOR_DEFINES_SVH
`define HILL_TERRAIN_ACCUMULATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define HTA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HTA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define HTA_ASSERT(label, clk, rst, prop, msg)
`define HTA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/hta_pkg.sv
// Package for the hill terrain accumulator: transaction types, codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
package hta_pkg;

   localparam int DefMaxRows   = 256;
   localparam int DefMaxCols   = 256;
   localparam int DefHeightBits = 16;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_COLUMN_COUNT = 1'b1;

   localparam logic [8:0] COUNT_RESET = 9'd256;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  radius;
      logic [15:0] peak;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_height;
      logic [1:0]  op_echo;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CELL,
      ST_NUM,
      ST_DIV,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

// File: rtl/hill_terrain_accumulator.sv
// Hill terrain accumulator: a grid of cell heights in one synchronous memory.
// Depends on hta_pkg and hill_terrain_accumulator_defines.svh.
//
// Use: transactions arrive on req_ (valid/stall) as one of add hill, read cell
// or clear grid; every transaction gives exactly one response on rsp_, which
// carries the height read (zero otherwise) and the operation code it ends.
// The csr_ port writes row_count (index 0) and column_count (index 1); it is
// always ready and should only be used while the block is idle.
//
// Sequencing: a read goes through a memory read state to its response, a
// zero-radius hill or an unknown code straight to completion. An add-hill
// sweeps the 2R by 2R square one cell at a time through the single memory:
// a cell outside the hill is dropped once its numerator proves negative, a
// cell inside it goes through squares, product, a sixteen-step restoring
// divide and the write-back, and a whole row outside the grid is skipped.
// Each cell is read and written back before the next is touched, so no two
// accesses to one entry ever overlap.
//
// Reset and clear: after reset, and for every clear transaction, the block
// sweeps the whole memory writing zeros, one entry per cycle, over all
// 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (65536 by default); req_stall
// stays high during the sweep. The response sits in an output register, so a
// stalled receiver holds it; the block can accept the next transaction
// meanwhile and only waits when it has another response ready.
`timescale 1ns / 1ps
`include "hill_terrain_accumulator_defines.svh"
module hill_terrain_accumulator #(
   parameter int MAX_ROWS    = hta_pkg::DefMaxRows,
   parameter int MAX_COLS    = hta_pkg::DefMaxCols,
   parameter int HEIGHT_BITS = hta_pkg::DefHeightBits
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hta_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hta_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [8:0]       csr_data
);

   localparam int RB    = $clog2(MAX_ROWS);
   localparam int CB    = $clog2(MAX_COLS);
   localparam int AW    = RB + CB;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = ((HEIGHT_BITS > 16) ? HEIGHT_BITS : 16) + 1;
   localparam logic [SW-1:0] HEIGHT_ONE = SW'(1) << (HEIGHT_BITS - 1);

   // Height memory with registered read data.
   logic [HEIGHT_BITS-1:0] mem [DEPTH];
   logic [HEIGHT_BITS-1:0] mem_q_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [HEIGHT_BITS-1:0] wr_data;

   hta_pkg::state_type state_ff, state_in;

   logic [8:0]  row_count_ff, column_count_ff;
   logic [8:0]  row_lim, col_lim;

   logic [1:0]  func_ff;
   logic [7:0]  crow_ff, ccol_ff;
   logic [15:0] peak_ff;
   logic [15:0] r2_ff;
   logic signed [10:0] r_ff, c_ff, r_end_ff, c_start_ff, c_end_ff;
   logic [15:0] dx2_ff, dy2_ff;
   logic [15:0] rem_ff, quo_ff;
   logic [3:0]  div_cnt_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [15:0] res_height_ff;
   logic [1:0]  res_op_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_height_ff;
   logic [1:0]  rsp_op_ff;

   logic        req_accept;
   logic        row_ok, col_ok, last_row, last_col;
   logic signed [10:0] cr_s, cc_s, rad_s;
   logic signed [8:0]  dy, dx;
   logic signed [17:0] num;
   logic [16:0] div_t;
   logic        div_ge;
   logic [SW-1:0] sum, sum_sat;
   logic [AW-1:0] cell_addr;
   logic        rsp_load;

   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != hta_pkg::ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = '{cell_height: rsp_height_ff, op_echo: rsp_op_ff};

   // Grid in use is the register clipped to the memory's size.
   assign row_lim = (32'(row_count_ff) > MAX_ROWS) ? 9'(MAX_ROWS) : row_count_ff;
   assign col_lim = (32'(column_count_ff) > MAX_COLS) ? 9'(MAX_COLS) : column_count_ff;

   assign cr_s  = $signed({3'b000, req_payload.row});
   assign cc_s  = $signed({3'b000, req_payload.col});
   assign rad_s = $signed({3'b000, req_payload.radius});

   assign row_ok   = !r_ff[10] && (r_ff[9:0] < {1'b0, row_lim});
   assign col_ok   = !c_ff[10] && (c_ff[9:0] < {1'b0, col_lim});
   assign last_row = (r_ff == r_end_ff);
   assign last_col = (c_ff == c_end_ff);

   assign dy = 9'($signed({3'b000, crow_ff}) - r_ff);
   assign dx = 9'($signed({3'b000, ccol_ff}) - c_ff);

   assign num = $signed({2'b00, r2_ff}) - $signed({2'b00, dx2_ff})
              - $signed({2'b00, dy2_ff});

   assign div_t  = {rem_ff, quo_ff[15]};
   assign div_ge = (div_t >= {1'b0, r2_ff});

   assign sum     = SW'(mem_q_ff) + SW'(quo_ff);
   assign sum_sat = (sum > HEIGHT_ONE) ? HEIGHT_ONE : sum;

   assign cell_addr = {RB'(r_ff[9:0]), CB'(c_ff[9:0])};

   assign rsp_load = (state_ff == hta_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Next state and memory port control.
   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      rd_addr  = cell_addr;
      wr_en    = 1'b0;
      wr_addr  = cell_addr;
      wr_data  = HEIGHT_BITS'(sum_sat);
      unique case (state_ff)
         hta_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = (func_ff == hta_pkg::FUNC_CLEAR) ? hta_pkg::ST_DONE
                                                           : hta_pkg::ST_IDLE;
            end
         end
         hta_pkg::ST_IDLE: begin
            rd_addr = {RB'(req_payload.row), CB'(req_payload.col)};
            if (req_accept) begin
               priority if (req_payload.func == hta_pkg::FUNC_ADD) begin
                  state_in = (req_payload.radius == 8'd0) ? hta_pkg::ST_DONE
                                                          : hta_pkg::ST_CELL;
               end else if (req_payload.func == hta_pkg::FUNC_READ) begin
                  rd_en    = 1'b1;
                  state_in = hta_pkg::ST_READ;
               end else if (req_payload.func == hta_pkg::FUNC_CLEAR) begin
                  state_in = hta_pkg::ST_CLEAR;
               end else begin
                  state_in = hta_pkg::ST_DONE;
               end
            end
         end
         hta_pkg::ST_READ: begin
            state_in = hta_pkg::ST_DONE;
         end
         hta_pkg::ST_CELL: begin
            if (row_ok && col_ok) begin
               state_in = hta_pkg::ST_NUM;
            end else if ((!row_ok || last_col) && last_row) begin
               state_in = hta_pkg::ST_DONE;
            end
         end
         hta_pkg::ST_NUM: begin
            if (num[17]) begin
               if (last_col && last_row) begin
                  state_in = hta_pkg::ST_DONE;
               end else begin
                  state_in = hta_pkg::ST_CELL;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = hta_pkg::ST_DIV;
            end
         end
         hta_pkg::ST_DIV: begin
            if (div_cnt_ff == 4'd0) begin
               state_in = hta_pkg::ST_WRITE;
            end
         end
         hta_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            state_in = (last_col && last_row) ? hta_pkg::ST_DONE : hta_pkg::ST_CELL;
         end
         hta_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = hta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hta_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // Configuration registers and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= hta_pkg::COUNT_RESET;
         column_count_ff <= hta_pkg::COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
         clr_addr_ff     <= '0;
         func_ff         <= hta_pkg::FUNC_ADD;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == hta_pkg::CSR_ROW_COUNT) begin
               row_count_ff <= csr_data;
            end else begin
               column_count_ff <= csr_data;
            end
         end
         // The output register is loaded only when the response goes out, so
         // a stalled response is untouched by the next transaction's work.
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_height_ff <= res_height_ff;
            rsp_op_ff     <= res_op_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == hta_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (req_accept) begin
            func_ff <= req_payload.func;
         end
      end
   end

   // Sweep and arithmetic datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         hta_pkg::ST_IDLE: begin
            crow_ff       <= req_payload.row;
            ccol_ff       <= req_payload.col;
            peak_ff       <= req_payload.peak;
            r2_ff         <= 16'(req_payload.radius * req_payload.radius);
            // A read transaction checks its cell against the grid through r_ff/c_ff.
            r_ff          <= (req_payload.func == hta_pkg::FUNC_READ) ? cr_s : cr_s - rad_s;
            c_ff          <= (req_payload.func == hta_pkg::FUNC_READ) ? cc_s : cc_s - rad_s;
            c_start_ff    <= cc_s - rad_s;
            r_end_ff      <= cr_s + rad_s - 11'sd1;
            c_end_ff      <= cc_s + rad_s - 11'sd1;
            res_op_ff     <= req_payload.func;
            res_height_ff <= '0;
         end
         hta_pkg::ST_READ: begin
            if (row_ok && col_ok) begin
               res_height_ff <= 16'(mem_q_ff);
            end
         end
         hta_pkg::ST_CELL: begin
            dy2_ff <= 16'(dy * dy);
            dx2_ff <= 16'(dx * dx);
            if (!row_ok) begin
               r_ff <= r_ff + 11'sd1;
               c_ff <= c_start_ff;
            end else if (!col_ok) begin
               if (last_col) begin
                  r_ff <= r_ff + 11'sd1;
                  c_ff <= c_start_ff;
               end else begin
                  c_ff <= c_ff + 11'sd1;
               end
            end
         end
         hta_pkg::ST_NUM: begin
            {rem_ff, quo_ff} <= peak_ff * num[15:0];
            div_cnt_ff       <= 4'd15;
            if (num[17]) begin
               if (last_col) begin
                  r_ff <= r_ff + 11'sd1;
                  c_ff <= c_start_ff;
               end else begin
                  c_ff <= c_ff + 11'sd1;
               end
            end
         end
         hta_pkg::ST_DIV: begin
            rem_ff     <= div_ge ? 16'(div_t - {1'b0, r2_ff}) : div_t[15:0];
            quo_ff     <= {quo_ff[14:0], div_ge};
            div_cnt_ff <= div_cnt_ff - 4'd1;
         end
         hta_pkg::ST_WRITE: begin
            if (last_col) begin
               r_ff <= r_ff + 11'sd1;
               c_ff <= c_start_ff;
            end else begin
               c_ff <= c_ff + 11'sd1;
            end
         end
         default: begin
         end
      endcase
   end

   `HTA_ASSERT_IMP(a_div_nonzero, clock, reset, state_ff == hta_pkg::ST_DIV, r2_ff != 16'd0, "divide by zero radius")
   `HTA_ASSERT_IMP(a_write_in_grid, clock, reset, state_ff == hta_pkg::ST_WRITE, row_ok && col_ok, "write-back outside grid")
   `HTA_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == hta_pkg::ST_DONE, "response without completion")
   `HTA_ASSERT_IMP(a_sum_saturated, clock, reset, wr_en && state_ff == hta_pkg::ST_WRITE, sum_sat <= HEIGHT_ONE, "height above one")

endmodule

// File: tb/hill_terrain_accumulator_tb.sv
// Self-checking testbench for the hill terrain accumulator: hills, reads, clears and grid sizes.
// Uses hta_pkg and the hill_terrain_accumulator top level; predicts every response internally.
`timescale 1ns / 1ps
module hill_terrain_accumulator_tb;

   localparam int GRID_ROWS = 256;
   localparam int GRID_COLS = 256;
   localparam logic [15:0] HEIGHT_FULL = 16'd32768;
   // Unknown operation code; the block answers it with a zero height.
   localparam logic [1:0] FUNC_NONE = 2'd3;
   // Margin for any work still running when the last response has arrived.
   localparam int SETTLE_CYCLES = 64;
   // Hang limit for the whole run, which holds up to four clearing sweeps of 65536 entries each.
   localparam int CYCLE_LIMIT = 4000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   hta_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   hta_pkg::rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_index;
   logic [8:0] csr_data;

   // Own copy of the terrain and of the two count registers.
   logic [15:0] terrain [GRID_ROWS * GRID_COLS];
   logic [8:0]  rows_reg;
   logic [8:0]  cols_reg;
   hta_pkg::rsp_type pending_responses[$];

   int error_count;
   int cycle_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   int clears_left;

   hill_terrain_accumulator uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // The cycle counter guards against a hang anywhere in the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver stalls at random, changing only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Every response transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      hta_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $error("unexpected response: cell_height %0d op_echo %0d",
                   rsp_payload.cell_height, rsp_payload.op_echo);
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_payload.cell_height !== want.cell_height) begin
               $error("cell_height: expected %0d, actual %0d",
                      want.cell_height, rsp_payload.cell_height);
               error_count++;
            end
            if (rsp_payload.op_echo !== want.op_echo) begin
               $error("op_echo: expected %0d, actual %0d", want.op_echo, rsp_payload.op_echo);
               error_count++;
            end
         end
      end
   end

   function automatic int rows_in_use();
      return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
   endfunction

   function automatic int cols_in_use();
      return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
   endfunction

   // Applies one transaction to the terrain copy and returns its response.
   function automatic hta_pkg::rsp_type terrain_step(hta_pkg::req_type item);
      hta_pkg::rsp_type answer;
      int      rad;
      longint  r2;
      longint  num;
      longint  total;
      int      idx;
      answer.cell_height = '0;
      answer.op_echo = item.func;
      rad = item.radius;
      r2 = longint'(rad) * rad;
      case (item.func)
         hta_pkg::FUNC_ADD: begin
            if (rad != 0) begin
               for (int r = int'(item.row) - rad; r < int'(item.row) + rad; r++) begin
                  if (r < 0 || r >= rows_in_use()) continue;
                  for (int c = int'(item.col) - rad; c < int'(item.col) + rad; c++) begin
                     if (c < 0 || c >= cols_in_use()) continue;
                     num = r2 - longint'(int'(item.col) - c) * (int'(item.col) - c)
                              - longint'(int'(item.row) - r) * (int'(item.row) - r);
                     if (num < 0) continue;
                     idx = r * GRID_COLS + c;
                     total = longint'(terrain[idx]) + (longint'(item.peak) * num) / r2;
                     if (total > HEIGHT_FULL) total = HEIGHT_FULL;
                     terrain[idx] = total[15:0];
                  end
               end
            end
         end
         hta_pkg::FUNC_READ: begin
            if (item.row < rows_in_use() && item.col < cols_in_use())
               answer.cell_height = terrain[int'(item.row) * GRID_COLS + int'(item.col)];
         end
         hta_pkg::FUNC_CLEAR: begin
            foreach (terrain[i]) terrain[i] = '0;
         end
         default: ;
      endcase
      return answer;
   endfunction

   // Sends one request transaction, with a random idle gap before it. The
   // valid stays high afterwards so back-to-back transactions need no gap.
   task automatic send_request(hta_pkg::req_type item);
      @(negedge clock);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_responses.push_back(terrain_step(item));
   endtask

   // Stops sending and waits until every response has arrived, then lets
   // the block finish any work that has no response still to come.
   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_responses.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(logic index, logic [8:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (index == hta_pkg::CSR_ROW_COUNT) rows_reg = value;
      else cols_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_grid(logic [8:0] nrows, logic [8:0] ncols);
      wait_for_quiet();
      write_count(hta_pkg::CSR_ROW_COUNT, nrows);
      write_count(hta_pkg::CSR_COLUMN_COUNT, ncols);
   endtask

   function automatic hta_pkg::req_type make_request(logic [1:0] func, int row, int col,
                                                     int radius, int peak);
      hta_pkg::req_type item;
      item.func = func;
      item.row = row[7:0];
      item.col = col[7:0];
      item.radius = radius[7:0];
      item.peak = peak[15:0];
      return item;
   endfunction

   // Corners, saturation, peaks above one and code three.
   task automatic test_directed_hills();
      send_request(make_request(hta_pkg::FUNC_READ, 0, 0, 0, 0));
      send_request(make_request(hta_pkg::FUNC_READ, 255, 255, 255, 65535));
      send_request(make_request(hta_pkg::FUNC_ADD, 0, 0, 1, 32768));
      send_request(make_request(hta_pkg::FUNC_READ, 0, 0, 0, 0));
      send_request(make_request(hta_pkg::FUNC_ADD, 255, 255, 2, 65535));
      send_request(make_request(hta_pkg::FUNC_ADD, 255, 255, 2, 65535));
      send_request(make_request(hta_pkg::FUNC_READ, 255, 255, 0, 0));
      send_request(make_request(hta_pkg::FUNC_READ, 254, 255, 0, 0));
      send_request(make_request(hta_pkg::FUNC_ADD, 20, 30, 0, 32768));
      send_request(make_request(hta_pkg::FUNC_READ, 20, 30, 0, 0));
      send_request(make_request(hta_pkg::FUNC_ADD, 40, 40, 3, 12345));
      send_request(make_request(hta_pkg::FUNC_READ, 40, 41, 0, 0));
      send_request(make_request(FUNC_NONE, 40, 40, 3, 65535));
      send_request(make_request(hta_pkg::FUNC_READ, 40, 40, 0, 0));
   endtask

   // Tiny, empty and oversized grids, with a full-size hill clipped to them.
   task automatic test_grid_limits();
      set_grid(9'd1, 9'd3);
      send_request(make_request(hta_pkg::FUNC_ADD, 128, 1, 255, 65535));
      send_request(make_request(hta_pkg::FUNC_READ, 0, 1, 0, 0));
      send_request(make_request(hta_pkg::FUNC_READ, 1, 0, 0, 0));
      set_grid(9'd0, 9'd0);
      send_request(make_request(hta_pkg::FUNC_ADD, 0, 0, 4, 30000));
      send_request(make_request(hta_pkg::FUNC_READ, 0, 0, 0, 0));
      set_grid(9'd511, 9'd511);
      send_request(make_request(hta_pkg::FUNC_READ, 0, 1, 0, 0));
      send_request(make_request(hta_pkg::FUNC_ADD, 250, 2, 7, 20000));
      send_request(make_request(hta_pkg::FUNC_READ, 250, 2, 0, 0));
   endtask

   // A clear must wipe cells outside the grid in use as well.
   task automatic test_clear();
      set_grid(9'd4, 9'd4);
      send_request(make_request(hta_pkg::FUNC_CLEAR, 0, 0, 0, 0));
      set_grid(9'd256, 9'd256);
      send_request(make_request(hta_pkg::FUNC_READ, 250, 2, 0, 0));
      send_request(make_request(hta_pkg::FUNC_READ, 0, 1, 0, 0));
   endtask

   function automatic hta_pkg::req_type random_request(ref int hill_row, ref int hill_col);
      hta_pkg::req_type item;
      int      pick;
      int      span;
      item.peak = $urandom_range(0, 3) == 0 ? 16'(HEIGHT_FULL) : 16'($urandom);
      item.radius = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         span = rows_in_use() + 3;
         item.func = hta_pkg::FUNC_ADD;
         item.row = 8'($urandom_range(0, span > 255 ? 255 : span));
         span = cols_in_use() + 3;
         item.col = 8'($urandom_range(0, span > 255 ? 255 : span));
         pick = $urandom_range(0, 99);
         if (pick < 10) item.radius = 0;
         else if (pick < 94) item.radius = 8'($urandom_range(1, 6));
         else item.radius = 8'($urandom_range(7, 24));
         hill_row = item.row;
         hill_col = item.col;
      end else if (pick < 92) begin
         // Reads mostly land on or near the latest hill.
         item.func = hta_pkg::FUNC_READ;
         item.row = 8'(hill_row + $urandom_range(0, 6) - 3);
         item.col = 8'(hill_col + $urandom_range(0, 6) - 3);
         if ($urandom_range(0, 4) == 0) begin
            item.row = 8'($urandom);
            item.col = 8'($urandom);
         end
      end else if (pick < 96 && clears_left > 0) begin
         item.func = hta_pkg::FUNC_CLEAR;
         clears_left--;
         item.row = 8'($urandom);
         item.col = 8'($urandom);
      end else begin
         item.func = FUNC_NONE;
         item.row = 8'($urandom);
         item.col = 8'($urandom);
      end
      return item;
   endfunction

   task automatic test_random_phase(int idle_pct, int stall_pct, logic [8:0] nrows,
                                    logic [8:0] ncols, int items);
      int hill_row;
      int hill_col;
      hill_row = 0;
      hill_col = 0;
      set_grid(nrows, ncols);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < items; n++) begin
         send_request(random_request(hill_row, hill_col));
         // Halfway through, the sender holds back until all responses are in.
         if (n == items / 2) wait_for_quiet();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = hta_pkg::CSR_ROW_COUNT;
      csr_data = '0;
      error_count = 0;
      cycle_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      clears_left = 2;
      rows_reg = hta_pkg::COUNT_RESET;
      cols_reg = hta_pkg::COUNT_RESET;
      foreach (terrain[i]) terrain[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // The block clears its memory after reset; nothing goes in until then.
      @(negedge clock);
      wait (!req_stall);

      test_directed_hills();
      test_grid_limits();
      test_clear();
      test_random_phase(0, 0, 9'd256, 9'd256, 30);
      test_random_phase(58, 0, 9'd37, 9'd200, 30);
      test_random_phase(0, 58, 9'd300, 9'd12, 30);
      test_random_phase(28, 28, 9'd256, 9'd256, 30);

      wait_for_quiet();
      if (pending_responses.size() != 0) begin
         $error("%0d responses never arrived", pending_responses.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/hta_pkg.sv
rtl/hill_terrain_accumulator.sv
tb/hill_terrain_accumulator_tb.sv
